/* hw/rtl/lcas_pkg.sv */
// Shared types and constants for the toroidal Life engine.
// Holds the operation codes, the sequencer states and the change-count control bundle.
// No dependencies.
package lcas_pkg;

   localparam int ROW_FIELD_W = 5;
   localparam int COL_FIELD_W = 5;
   localparam int COUNT_W     = 11;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Neighbour counts of Conway's rule.
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_STEP  = 2'd2
   } op_type;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_ACCESS = 5'b00100,
      ST_SWEEP  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   typedef struct packed {
      logic start;
      logic valid;
      logic last;
   } count_ctl_type;

endpackage

/* hw/rtl/lcas_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module lcas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/lcas_rule.sv */
// Next-generation logic for one row of the grid, with columns wrapping at both edges.
// Depends on lcas_pkg for the neighbour counts of the rule.
module lcas_rule #(
   parameter int COLS = 32
) (
   input  logic [COLS-1:0] row_up,
   input  logic [COLS-1:0] row_mid,
   input  logic [COLS-1:0] row_dn,
   output logic [COLS-1:0] row_next
);
   import lcas_pkg::*;

   for (genvar c = 0; c < COLS; c++) begin : g_col
      localparam int CL = (c == 0) ? COLS - 1 : c - 1;
      localparam int CR = (c == COLS - 1) ? 0 : c + 1;

      logic [3:0] nbrs;

      assign nbrs = 4'(row_up[CL]) + 4'(row_up[c]) + 4'(row_up[CR])
                  + 4'(row_mid[CL]) + 4'(row_mid[CR])
                  + 4'(row_dn[CL]) + 4'(row_dn[c]) + 4'(row_dn[CR]);

      assign row_next[c] = (nbrs == BIRTH_COUNT) || (row_mid[c] && (nbrs == SURVIVE_COUNT));
   end

endmodule

/* hw/rtl/lcas_count.sv */
// Pipelined count of changed cells: registers the change word, counts bytes, then
// accumulates with saturation. Depends on lcas_pkg.
module lcas_count #(
   parameter int WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lcas_pkg::count_ctl_type        ctl,
   input  logic [WIDTH-1:0]               diff,
   output logic                           done,
   output logic [lcas_pkg::COUNT_W-1:0]   total
);
   import lcas_pkg::*;

   localparam int NB = (WIDTH + 7) / 8;
   localparam int PW = NB * 8;
   localparam int SW = $clog2(PW + 1);

   logic [PW-1:0]        diff_ff;
   logic                 v1_ff, last1_ff;
   logic [3:0]           bc_in [NB];
   logic [3:0]           bc_ff [NB];
   logic                 v2_ff, last2_ff;
   logic [SW-1:0]        psum;
   logic [COUNT_W:0]     acc;
   logic [COUNT_W-1:0]   total_ff, total_in;
   logic                 done_ff;

   always_comb begin
      for (int b = 0; b < NB; b++) begin
         bc_in[b] = 4'd0;
         for (int k = 0; k < 8; k++) begin
            bc_in[b] = bc_in[b] + 4'(diff_ff[b*8+k]);
         end
      end
   end

   always_comb begin
      psum = '0;
      for (int b = 0; b < NB; b++) begin
         psum = psum + SW'(bc_ff[b]);
      end
      acc = {1'b0, total_ff} + (COUNT_W+1)'(psum);
      if (acc[COUNT_W]) begin
         total_in = COUNT_MAX;
      end else begin
         total_in = acc[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= PW'(diff);
      bc_ff   <= bc_in;
      if (reset) begin
         v1_ff    <= 1'b0;
         last1_ff <= 1'b0;
         v2_ff    <= 1'b0;
         last2_ff <= 1'b0;
         done_ff  <= 1'b0;
         total_ff <= '0;
      end else begin
         v1_ff    <= ctl.valid;
         last1_ff <= ctl.last;
         v2_ff    <= v1_ff;
         last2_ff <= last1_ff;
         done_ff  <= v2_ff && last2_ff;
         if (ctl.start) begin
            total_ff <= '0;
         end else if (v2_ff) begin
            total_ff <= total_in;
         end
      end
   end

   assign done  = done_ff;
   assign total = total_ff;

`ifndef NO_ASSERTIONS
   a_start_not_mid_run: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !v1_ff && !v2_ff)
      else $error("count restarted while a run was still in the pipeline");
   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(v2_ff) && $past(last2_ff))
      else $error("count done without a final row");
   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      v2_ff |=> total_ff >= $past(total_ff) || $past(ctl.start))
      else $error("changed count went backwards during a run");
`endif

endmodule

/* hw/rtl/life_cell_automaton_step.sv */
// Toroidal Game of Life engine: grid memory, request sequencer and row-sweep window.
// Depends on lcas_pkg, lcas_ram, lcas_rule and lcas_count.
//
// The grid lives in one RAM, one word per row. After reset a clearing pass writes
// every row dead, and no transfer is accepted until it is done. A write of one cell
// is a read-modify-write of its row; a read of one cell only reads its row. Either
// passes through the access and finish states before the result is registered. A step
// sweeps the rows through a three-row window fed by the RAM read port at one row per
// cycle, writes each new row back in place and waits for the change-count pipeline.
// Items are handled one at a time; the next transfer is accepted while a result still
// waits in the output register.
module life_cell_automaton_step #(
   parameter int GRID_ROWS = 32,
   parameter int GRID_COLS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // row[4:0], col[9:5], cell_value[10], zero fill
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // read_value[0], changed_count[11:1], zero fill
);
   import lcas_pkg::*;

   localparam int ROW_AW = $clog2(GRID_ROWS);
   localparam int COL_AW = $clog2(GRID_COLS);
   localparam int RXW    = (ROW_AW > ROW_FIELD_W) ? ROW_AW : ROW_FIELD_W;
   localparam int CXW    = (COL_AW > COL_FIELD_W) ? COL_AW : COL_FIELD_W;
   localparam int IW     = $clog2(GRID_ROWS + 2);
   localparam int AW     = $clog2(GRID_ROWS + 3);

   localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(GRID_ROWS - 1);
   localparam logic [IW-1:0]     ISS_END  = IW'(GRID_ROWS);
   localparam logic [IW-1:0]     CLR_END  = IW'(GRID_ROWS - 1);
   localparam logic [AW-1:0]     ARR_INJ  = AW'(GRID_ROWS + 1);

   // Request fields.
   logic [ROW_FIELD_W-1:0] req_row;
   logic [COL_FIELD_W-1:0] req_col;
   logic                   req_cell_value;
   op_type                 req_op;
   logic [RXW-1:0]         row_ext;
   logic [CXW-1:0]         col_ext;
   logic                   req_inside;
   logic                   accept;

   assign req_row        = req_tdata[4:0];
   assign req_col        = req_tdata[9:5];
   assign req_cell_value = req_tdata[10];
   assign req_op         = op_type'(req_tuser);
   assign row_ext        = RXW'(req_row);
   assign col_ext        = CXW'(req_col);
   assign req_inside     = (int'(req_row) < GRID_ROWS) && (int'(req_col) < GRID_COLS);

   // Sequencer state.
   state_type            state_ff, state_in;
   logic [IW-1:0]        iss_ff, iss_in;
   logic [IW-1:0]        iss_prev;
   logic [AW-1:0]        arr_ff, arr_in;
   logic [AW-1:0]        arr_less2;
   logic                 rd_pend_ff, rd_pend_in;
   logic                 calc_ff, calc_in;
   logic                 calc_last_ff, calc_last_in;
   logic [ROW_AW-1:0]    calc_row_ff, calc_row_in;

   // Captured request.
   op_type               op_ff;
   logic [ROW_AW-1:0]    row_addr_ff;
   logic [COL_AW-1:0]    col_idx_ff;
   logic                 val_ff;
   logic                 inside_ff;

   // Window of old-generation rows.
   logic [GRID_COLS-1:0] win_up_ff, win_mid_ff, win_dn_ff, row0_ff;
   logic [GRID_COLS-1:0] arrive_word;
   logic                 arrive;
   logic [GRID_COLS-1:0] row_next;

   // Pending and output results.
   logic                 pend_rd_ff, pend_rd_in;
   logic [COUNT_W-1:0]   pend_cnt_ff, pend_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_rd_ff;
   logic [COUNT_W-1:0]   rsp_cnt_ff;
   logic                 out_free;

   // Memory port.
   logic                 mem_wr_en, mem_rd_en;
   logic [ROW_AW-1:0]    mem_wr_addr, mem_rd_addr;
   logic [GRID_COLS-1:0] mem_wr_data, mem_rd_data;
   logic [GRID_COLS-1:0] cell_mask;

   count_ctl_type        cnt_ctl;
   logic                 cnt_done;
   logic [COUNT_W-1:0]   cnt_total;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign iss_prev   = iss_ff - IW'(1);
   assign arr_less2  = arr_ff - AW'(2);
   assign cell_mask  = GRID_COLS'(1) << col_idx_ff;

   // After the RAM reads are done, the saved old row 0 is fed in as the row below
   // the last row.
   assign arrive      = rd_pend_ff
                      || ((state_ff == ST_SWEEP) && (arr_ff == ARR_INJ));
   assign arrive_word = rd_pend_ff ? mem_rd_data : row0_ff;

   always_comb begin
      state_in     = state_ff;
      iss_in       = iss_ff;
      arr_in       = arr_ff;
      rd_pend_in   = 1'b0;
      pend_rd_in   = pend_rd_ff;
      pend_cnt_in  = pend_cnt_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = calc_row_ff;
      mem_wr_data  = row_next;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = row_ext[ROW_AW-1:0];
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      calc_in      = arrive && (arr_ff >= AW'(2));
      calc_last_in = arr_ff == ARR_INJ;
      calc_row_in  = arr_less2[ROW_AW-1:0];
      if (arrive) begin
         arr_in = arr_ff + AW'(1);
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = iss_ff[ROW_AW-1:0];
            mem_wr_data = '0;
            iss_in      = iss_ff + IW'(1);
            if (iss_ff == CLR_END) begin
               iss_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               iss_in      = '0;
               arr_in      = '0;
               pend_rd_in  = 1'b0;
               pend_cnt_in = '0;
               case (req_op)
                  OP_WRITE, OP_READ: begin
                     mem_rd_en = 1'b1;
                     state_in  = ST_ACCESS;
                  end
                  OP_STEP: begin
                     state_in = ST_SWEEP;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_ACCESS: begin
            if ((op_ff == OP_WRITE) && inside_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = row_addr_ff;
               mem_wr_data = val_ff ? (mem_rd_data | cell_mask) : (mem_rd_data & ~cell_mask);
            end
            pend_rd_in = (op_ff == OP_READ) && inside_ff && mem_rd_data[col_idx_ff];
            state_in   = ST_FINISH;
         end
         ST_SWEEP: begin
            // Reads run from the last row through row 0 up to the last row again;
            // each row is read before its new value is written back in its place.
            if (iss_ff <= ISS_END) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = (iss_ff == '0) ? LAST_ROW : iss_prev[ROW_AW-1:0];
               rd_pend_in  = 1'b1;
               iss_in      = iss_ff + IW'(1);
            end
            mem_wr_en = calc_ff;
            if (cnt_done) begin
               pend_cnt_in = cnt_total;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_op;
         row_addr_ff <= row_ext[ROW_AW-1:0];
         col_idx_ff  <= col_ext[COL_AW-1:0];
         val_ff      <= req_cell_value;
         inside_ff   <= req_inside;
      end
      if (arrive) begin
         win_up_ff  <= win_mid_ff;
         win_mid_ff <= win_dn_ff;
         win_dn_ff  <= arrive_word;
         if (arr_ff == AW'(1)) begin
            row0_ff <= arrive_word;
         end
      end
      calc_row_ff  <= calc_row_in;
      calc_last_ff <= calc_last_in;
      pend_rd_ff   <= pend_rd_in;
      pend_cnt_ff  <= pend_cnt_in;
      if ((state_ff == ST_FINISH) && out_free) begin
         rsp_rd_ff  <= pend_rd_ff;
         rsp_cnt_ff <= pend_cnt_ff;
      end
      if (reset) begin
         state_ff     <= ST_CLEAR;
         iss_ff       <= '0;
         arr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         calc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         arr_ff       <= arr_in;
         rd_pend_ff   <= rd_pend_in;
         calc_ff      <= calc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   lcas_ram #(
      .WIDTH (GRID_COLS),
      .DEPTH (GRID_ROWS)
   ) u_grid (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   lcas_rule #(
      .COLS (GRID_COLS)
   ) u_rule (
      .row_up   (win_up_ff),
      .row_mid  (win_mid_ff),
      .row_dn   (win_dn_ff),
      .row_next (row_next)
   );

   assign cnt_ctl.start = accept && (req_op == OP_STEP);
   assign cnt_ctl.valid = calc_ff;
   assign cnt_ctl.last  = calc_ff && calc_last_ff;

   lcas_count #(
      .WIDTH (GRID_COLS)
   ) u_count (
      .clock (clock),
      .reset (reset),
      .ctl   (cnt_ctl),
      .diff  (win_mid_ff ^ row_next),
      .done  (cnt_done),
      .total (cnt_total)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_cnt_ff, rsp_rd_ff};

`ifndef NO_ASSERTIONS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state is not one-hot");
   a_no_row_overlap: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en && mem_rd_en |-> mem_wr_addr != mem_rd_addr)
      else $error("row read and written in the same cycle");
   a_calc_in_sweep: assert property (@(posedge clock) disable iff (reset)
      calc_ff |-> state_ff == ST_SWEEP)
      else $error("row update outside a step");
   a_arrivals_bounded: assert property (@(posedge clock) disable iff (reset)
      arr_ff <= AW'(GRID_ROWS + 2))
      else $error("window received too many rows");
   a_done_only_in_sweep: assert property (@(posedge clock) disable iff (reset)
      cnt_done |-> state_ff == ST_SWEEP)
      else $error("change count finished outside a step");
`endif

endmodule
